// ----- rtl/core/owtr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the one-wire temperature reader.
// No dependencies; every other file in rtl/core imports this package.
package owtr_pkg;

  // Width of one timing register.
  localparam int CFG_W = 10;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_RESET_LOW      = 3'd0;
  localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
  localparam logic [2:0] REG_WRITE_SETUP    = 3'd2;
  localparam logic [2:0] REG_WRITE_HOLD     = 3'd3;
  localparam logic [2:0] REG_READ_LOW       = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE    = 3'd5;
  localparam logic [2:0] REG_READ_RECOVER   = 3'd6;

  // Reset values of the timing registers, in ticks.
  localparam logic [CFG_W-1:0] RESET_LOW_DEF       = 10'd247;
  localparam logic [CFG_W-1:0] PRESENCE_SAMPLE_DEF = 10'd27;
  localparam logic [CFG_W-1:0] WRITE_SETUP_DEF     = 10'd5;
  localparam logic [CFG_W-1:0] WRITE_HOLD_DEF      = 10'd20;
  localparam logic [CFG_W-1:0] READ_LOW_DEF        = 10'd1;
  localparam logic [CFG_W-1:0] READ_SAMPLE_DEF     = 10'd1;
  localparam logic [CFG_W-1:0] READ_RECOVER_DEF    = 10'd17;

  // Command codes on the func field.
  localparam logic [2:0] FUNC_RESET = 3'd1;
  localparam logic [2:0] FUNC_WRITE = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_TEMP  = 3'd4;

  // Sensor ROM and function commands.
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  // Raw readings from this value up are negative.
  localparam logic [15:0] NEG_THRESHOLD = 16'h0FFF;

  // Read steps of a temperature read: low byte, then the last step, high byte.
  localparam logic [3:0] SEQ_LOW_BYTE  = 4'd7;
  localparam logic [3:0] SEQ_HIGH_BYTE = 4'd8;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_RISE  = 4'd3,
    PH_W_SETUP   = 4'd4,
    PH_W_HOLD    = 4'd5,
    PH_R_LOW     = 4'd6,
    PH_R_SAMPLE  = 4'd7,
    PH_R_RECOVER = 4'd8
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence_sample;
    logic [CFG_W-1:0] write_setup;
    logic [CFG_W-1:0] write_hold;
    logic [CFG_W-1:0] read_low;
    logic [CFG_W-1:0] read_sample;
    logic [CFG_W-1:0] read_recover;
  } cfg_regs_t;

  // One result item as produced by the engine.
  typedef struct packed {
    logic        temp_negative;
    logic [15:0] temp_tenths;
    logic [7:0]  rx_byte;
    logic        presence;
    logic        done_res;
    logic        busy_res;
    logic        drive_low;
  } result_t;

  typedef struct packed {
    logic        negative;
    logic [15:0] tenths;
  } temp_t;

  // Operation run at each step of a temperature read.
  function automatic op_t seq_kind(input logic [3:0] step);
    op_t k;
    case (step)
      4'd1, 4'd4:       k = OP_RESET;
      4'd2, 4'd3,
      4'd5, 4'd6:       k = OP_WRITE;
      4'd7, 4'd8:       k = OP_READ;
      default:          k = OP_NONE;
    endcase
    return k;
  endfunction

  // Byte sent at each write step of a temperature read.
  function automatic logic [7:0] seq_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd2, 4'd5: b = CMD_SKIP_ROM;
      4'd3:       b = CMD_CONVERT;
      4'd6:       b = CMD_READ_PAD;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // Sign and magnitude in tenths: magnitude * 0.625, truncated.
  function automatic temp_t temp_convert(input logic [15:0] raw);
    temp_t      t;
    logic [15:0] mag;
    logic [18:0] times5;
    t.negative = (raw >= NEG_THRESHOLD);
    mag        = t.negative ? (~raw + 16'd1) : raw;
    times5     = {1'b0, mag, 2'b00} + {3'b000, mag};
    t.tenths   = times5[18:3];
    return t;
  endfunction

endpackage

// ----- rtl/core/one_wire_temperature_reader.sv -----
`timescale 1ns / 1ps
// One-wire bus master that reads a temperature sensor, tick by tick.
//
// Channels: in_* carries one bus tick per transfer (command, byte to send,
// sampled line level); out_* returns one result per accepted tick (line
// drive, busy, done, presence, last received byte, temperature). The cfg_*
// APB port holds seven phase lengths in ticks at byte addresses 0..24.
// Output: the result of a tick is registered and on out_tdata in the cycle
// after its transfer. Throughput: one tick per cycle while in_tready is
// high; the state update for a tick is a single pass through the slot
// sequencer between the state registers and the output register.
// Stall: the output register frees up in the cycle it is taken, so in_tready
// is high whenever the output register is empty or being drained; a stalled
// receiver holds in_tready low and no tick is lost.
// Reset (rst_n, synchronous): the sequencer is idle, all reported values
// are zero, timing registers return to their defaults, no result is valid.
// Depends on owtr_pkg, owtr_cfg and owtr_engine.
module one_wire_temperature_reader #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [2:0] func, [10:3] tx_byte, [11] line_level, [15:12] zero
  input  logic [owtr_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] presence,
  // [11:4] rx_byte, [27:12] temp_tenths, [28] temp_negative, [31:29] zero
  output logic [owtr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [owtr_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [owtr_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [owtr_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);
  import owtr_pkg::*;

  cfg_regs_t             regs;
  result_t               result;
  logic                  in_fire;
  logic                  eng_idle;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  assign in_tready = ~out_tvalid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  owtr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .regs    (regs)
  );

  owtr_engine #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .func       (in_tdata[2:0]),
    .tx_byte    (in_tdata[10:3]),
    .line_level (in_tdata[11]),
    .regs       (regs),
    .result     (result),
    .idle       (eng_idle)
  );

  // Output register: loads on each accepted tick, clears when taken.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (in_fire) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {3'b000, result.temp_negative, result.temp_tenths,
                        result.rx_byte, result.presence, result.done_res,
                        result.busy_res, result.drive_low};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A finishing command always leaves the sequencer idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[2] && out_tdata_r[1]))
    else $error("done and busy reported on the same tick");

  // An idle tick with no command neither drives the bus nor starts work.
  a_idle_noop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eng_idle && (in_tdata[2:0] < FUNC_RESET || in_tdata[2:0] > FUNC_TEMP))
      |=> (out_tvalid_r && !out_tdata_r[0] && !out_tdata_r[1] && !out_tdata_r[2]))
    else $error("idle tick changed the bus or started a command");

  // The busy flag of each result matches the sequencer state that follows.
  a_busy_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_tvalid_r && (out_tdata_r[1] == !eng_idle)))
    else $error("busy flag disagrees with sequencer state");

endmodule

// ----- rtl/core/owtr_cfg.sv -----
`timescale 1ns / 1ps
// APB-style register file holding the seven bus timing registers.
// Depends on owtr_pkg.
module owtr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [owtr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [owtr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [owtr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output owtr_pkg::cfg_regs_t               regs
);
  import owtr_pkg::*;

  cfg_regs_t        regs_r;
  cfg_regs_t        regs_nxt;
  logic [2:0]       index;
  logic [CFG_W-1:0] wval;
  logic [CFG_W-1:0] rval;
  logic             wr_en;

  assign pready = 1'b1;
  assign index  = paddr[4:2];
  assign wval   = pwdata[CFG_W-1:0];
  assign wr_en  = psel & penable & pwrite & pready;
  assign regs   = regs_r;

  // Write decode: addresses past the last register are ignored.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (index)
        REG_RESET_LOW:       regs_nxt.reset_low       = wval;
        REG_PRESENCE_SAMPLE: regs_nxt.presence_sample = wval;
        REG_WRITE_SETUP:     regs_nxt.write_setup     = wval;
        REG_WRITE_HOLD:      regs_nxt.write_hold      = wval;
        REG_READ_LOW:        regs_nxt.read_low        = wval;
        REG_READ_SAMPLE:     regs_nxt.read_sample     = wval;
        REG_READ_RECOVER:    regs_nxt.read_recover    = wval;
        default:             regs_nxt = regs_r;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (index)
      REG_RESET_LOW:       rval = regs_r.reset_low;
      REG_PRESENCE_SAMPLE: rval = regs_r.presence_sample;
      REG_WRITE_SETUP:     rval = regs_r.write_setup;
      REG_WRITE_HOLD:      rval = regs_r.write_hold;
      REG_READ_LOW:        rval = regs_r.read_low;
      REG_READ_SAMPLE:     rval = regs_r.read_sample;
      REG_READ_RECOVER:    rval = regs_r.read_recover;
      default:             rval = '0;
    endcase
  end

  assign prdata = {{(APB_DATA_W-CFG_W){1'b0}}, rval};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low       <= RESET_LOW_DEF;
      regs_r.presence_sample <= PRESENCE_SAMPLE_DEF;
      regs_r.write_setup     <= WRITE_SETUP_DEF;
      regs_r.write_hold      <= WRITE_HOLD_DEF;
      regs_r.read_low        <= READ_LOW_DEF;
      regs_r.read_sample     <= READ_SAMPLE_DEF;
      regs_r.read_recover    <= READ_RECOVER_DEF;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ----- rtl/core/owtr_engine.sv -----
`timescale 1ns / 1ps
// Bus sequencer: advances the one-wire slot state machine by one tick per
// accepted item and forms that tick's result. Depends on owtr_pkg.
module owtr_engine #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [2:0]           func,
  input  logic [7:0]           tx_byte,
  input  logic                 line_level,
  input  owtr_pkg::cfg_regs_t  regs,
  output owtr_pkg::result_t    result,
  output logic                 idle
);
  import owtr_pkg::*;

  localparam int CMPW = ((TICK_COUNT_BITS > CFG_W) ? TICK_COUNT_BITS : CFG_W) + 1;

  phase_t                     phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [2:0]                 bit_r, bit_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic [3:0]                 seq_r, seq_nxt;
  logic [7:0]                 low_byte_r, low_byte_nxt;
  logic [7:0]                 rx_r, rx_nxt;
  logic                       pres_r, pres_nxt;
  logic [15:0]                tenths_r, tenths_nxt;
  logic                       neg_r, neg_nxt;

  assign idle = (phase_r == PH_IDLE);

  // Phase entered when an operation starts.
  function automatic phase_t op_phase(input op_t op);
    phase_t p;
    case (op)
      OP_RESET: p = PH_RST_LOW;
      OP_WRITE: p = PH_W_SETUP;
      default:  p = PH_R_LOW;
    endcase
    return p;
  endfunction

  // One tick: command start, phase work, then the finish of an operation.
  always_comb begin
    logic [CFG_W-1:0] len;
    logic [CMPW-1:0]  lim;
    logic [CMPW-1:0]  c_ext;
    logic             plast;
    logic [TICK_COUNT_BITS-1:0] cnt_step;
    logic             fin;
    logic             drive;
    logic             done;
    op_t              op;
    temp_t            t;

    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    seq_nxt      = seq_r;
    low_byte_nxt = low_byte_r;
    rx_nxt       = rx_r;
    pres_nxt     = pres_r;
    tenths_nxt   = tenths_r;
    neg_nxt      = neg_r;
    fin          = 1'b0;
    drive        = 1'b0;
    done         = 1'b0;
    op           = OP_NONE;
    t            = '0;

    // A command taken while idle; its first tick is this one.
    if (phase_r == PH_IDLE && func >= FUNC_RESET && func <= FUNC_TEMP) begin
      if (func == FUNC_TEMP) begin
        seq_nxt = 4'd1;
        op      = seq_kind(4'd1);
      end else begin
        seq_nxt = 4'd0;
        op      = op_t'(func[1:0]);
      end
      cnt_nxt   = '0;
      bit_nxt   = 3'd0;
      phase_nxt = op_phase(op);
      shift_nxt = (op == OP_WRITE) ? tx_byte : 8'h00;
    end

    // Length of the current timed phase and its end-of-phase test.
    case (phase_nxt)
      PH_RST_LOW:   len = regs.reset_low;
      PH_RST_WAIT:  len = regs.presence_sample;
      PH_W_SETUP:   len = regs.write_setup;
      PH_W_HOLD:    len = regs.write_hold;
      PH_R_LOW:     len = regs.read_low;
      PH_R_SAMPLE:  len = regs.read_sample;
      PH_R_RECOVER: len = regs.read_recover;
      default:      len = '0;
    endcase
    lim      = (len == '0) ? CMPW'(1) : CMPW'(len);
    c_ext    = CMPW'(cnt_nxt);
    plast    = ((c_ext + CMPW'(1)) >= lim) || (cnt_nxt == '1);
    cnt_step = plast ? '0 : (cnt_nxt + TICK_COUNT_BITS'(1));

    unique case (phase_nxt)
      PH_IDLE: begin
      end
      PH_RST_LOW: begin
        drive   = 1'b1;
        cnt_nxt = cnt_step;
        if (plast) phase_nxt = PH_RST_WAIT;
      end
      PH_RST_WAIT: begin
        cnt_nxt = cnt_step;
        if (plast) begin
          if (!line_level) begin
            pres_nxt  = 1'b1;
            phase_nxt = PH_RST_RISE;
          end else begin
            pres_nxt = 1'b0;
            fin      = 1'b1;
          end
        end
      end
      PH_RST_RISE: begin
        // Waits with no timeout for the line to come back high.
        if (line_level) fin = 1'b1;
      end
      PH_W_SETUP: begin
        drive   = 1'b1;
        cnt_nxt = cnt_step;
        if (plast) phase_nxt = PH_W_HOLD;
      end
      PH_W_HOLD: begin
        drive   = ~shift_nxt[0];
        cnt_nxt = cnt_step;
        if (plast) begin
          shift_nxt = {1'b0, shift_nxt[7:1]};
          bit_nxt   = bit_nxt + 3'd1;
          if (bit_nxt == 3'd0) fin = 1'b1;
          else phase_nxt = PH_W_SETUP;
        end
      end
      PH_R_LOW: begin
        drive   = 1'b1;
        cnt_nxt = cnt_step;
        if (plast) phase_nxt = PH_R_SAMPLE;
      end
      PH_R_SAMPLE: begin
        cnt_nxt = cnt_step;
        if (plast) begin
          if (line_level) shift_nxt[bit_nxt] = 1'b1;
          phase_nxt = PH_R_RECOVER;
        end
      end
      PH_R_RECOVER: begin
        cnt_nxt = cnt_step;
        if (plast) begin
          bit_nxt = bit_nxt + 3'd1;
          if (bit_nxt == 3'd0) begin
            if (seq_nxt == 4'd0) rx_nxt = shift_nxt;
            fin = 1'b1;
          end else begin
            phase_nxt = PH_R_LOW;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        seq_nxt   = 4'd0;
      end
    endcase

    // End of an operation: report, or move to the next sequence step.
    if (fin) begin
      phase_nxt = PH_IDLE;
      if (seq_nxt == 4'd0 || seq_nxt > SEQ_HIGH_BYTE) begin
        seq_nxt = 4'd0;
        done    = 1'b1;
      end else if (seq_nxt == SEQ_HIGH_BYTE) begin
        t          = temp_convert({shift_nxt, low_byte_nxt});
        neg_nxt    = t.negative;
        tenths_nxt = t.tenths;
        seq_nxt    = 4'd0;
        done       = 1'b1;
      end else begin
        if (seq_nxt == SEQ_LOW_BYTE) low_byte_nxt = shift_nxt;
        seq_nxt   = seq_nxt + 4'd1;
        op        = seq_kind(seq_nxt);
        cnt_nxt   = '0;
        bit_nxt   = 3'd0;
        phase_nxt = op_phase(op);
        shift_nxt = (op == OP_WRITE) ? seq_byte(seq_nxt) : 8'h00;
      end
    end

    result.drive_low     = drive;
    result.busy_res      = (phase_nxt != PH_IDLE);
    result.done_res      = done;
    result.presence      = pres_nxt;
    result.rx_byte       = rx_nxt;
    result.temp_tenths   = tenths_nxt;
    result.temp_negative = neg_nxt;
  end

  // State advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cnt_r      <= '0;
      bit_r      <= 3'd0;
      shift_r    <= 8'h00;
      seq_r      <= 4'd0;
      low_byte_r <= 8'h00;
      rx_r       <= 8'h00;
      pres_r     <= 1'b0;
      tenths_r   <= 16'h0000;
      neg_r      <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      seq_r      <= seq_nxt;
      low_byte_r <= low_byte_nxt;
      rx_r       <= rx_nxt;
      pres_r     <= pres_nxt;
      tenths_r   <= tenths_nxt;
      neg_r      <= neg_nxt;
    end
  end

endmodule
